// ===== rtl/cbs_pkg.sv =====
// Shared types and constants for the codebook background subtractor.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
package cbs_pkg;

    localparam int PIXELS   = 65536;
    localparam int ENTRIES  = 8;
    localparam int CHANNELS = 3;

    localparam int PIX_W   = 16;
    localparam int K_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = 4;
    localparam int TIME_W  = 16;
    localparam int CW_AW   = PIX_W + K_W;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [7:0]        CH_MAX   = 8'hFF;
    localparam logic [CNT_W-1:0]  ENTRIES_C = CNT_W'(ENTRIES);

    // Configuration register indexes and reset values
    localparam logic [1:0] REG_LEARN_BOUND = 2'd0;
    localparam logic [1:0] REG_MIN_MARGIN  = 2'd1;
    localparam logic [1:0] REG_MAX_MARGIN  = 2'd2;
    localparam logic [7:0] LEARN_BOUND_RST = 8'd10;
    localparam logic [7:0] MIN_MARGIN_RST  = 8'd20;
    localparam logic [7:0] MAX_MARGIN_RST  = 8'd20;

    // Operation codes
    localparam logic [1:0] OP_LEARN = 2'd0;
    localparam logic [1:0] OP_DIFF  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_UNDEF = 2'd3;

    typedef logic [CHANNELS-1:0][7:0] t_pix;

    typedef struct packed {
        logic [TIME_W-1:0] stale;
        logic [TIME_W-1:0] last_upd;
        t_pix              bot;
        t_pix              top;
        t_pix              learn_lo;
        t_pix              learn_hi;
    } t_cword;

    typedef struct packed {
        logic [TIME_W-1:0] ptime;
        logic [CNT_W-1:0]  count;
    } t_hdr;

    // Results of the shared codeword unit
    typedef struct packed {
        logic learn_hit;
        logic diff_hit;
        logic keep;
    } t_cw_flags;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_SCAN,
        ST_FIN
    } t_state;

endpackage

// ===== rtl/codebook_background_subtractor_core.sv =====
// Codebook background subtractor. Each request (tuser = op: learn, background
// test, clear) names a pixel and its Y/Cr/Cb value and yields one result.
// A request goes through these steps: taking the request, a header read, a scan of
// the pixel's N codewords (N being its codeword count, 0..8) through the
// shared codeword unit and the codeword memory's read/write ports, and a
// write-back, which waits while an earlier result is still held at the output.
// After reset the pixel header memory is swept to zero, during which no request
// is taken; configuration writes are taken at any time.
`timescale 1ns / 1ps
module codebook_background_subtractor_core import cbs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [15:0] pixel_index, [23:16] luma, [31:24] chroma_red, [39:32] chroma_blue
    input  logic [39:0] i_s_tdata,
    // [1:0] op
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] foreground, [4:1] entry_count, [5] added, [6] dropped, [7] zero
    output logic [7:0]  o_m_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_state            r_state, n_state;
    logic [1:0]        r_op;
    logic [PIX_W-1:0]  r_px;
    t_pix              r_pix, r_box_hi, r_box_lo;
    logic [TIME_W-1:0] r_t;
    logic [CNT_W-1:0]  r_cnt, r_keep;
    logic [K_W-1:0]    r_k;
    logic              r_found;
    logic [7:0]        r_learn_bound, r_min_margin, r_max_margin;
    logic              r_out_valid;
    logic [7:0]        r_out_data;

    t_hdr              hdr_q, hdr_wdata;
    logic              hdr_busy, hdr_we;
    logic              accept;

    t_cword            cw_mem [PIXELS*ENTRIES];
    t_cword            r_cw_q;
    logic              cw_re, cw_we;
    logic [K_W-1:0]    cw_rk, cw_wk;
    t_cword            cw_wdata, cw_new;
    t_cw_flags         flags;
    t_cword            cw_hit, cw_aged, cw_kept;

    logic [TIME_W-1:0] t_learn;
    logic              more, fin_go;
    logic [CNT_W-1:0]  fin_cnt;
    logic              fin_added, fin_dropped, fin_fg;

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == ST_IDLE) && !hdr_busy;
    assign more       = ({1'b0, r_k} + 1'b1) < r_cnt;
    assign fin_go     = !r_out_valid || i_m_tready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_bound <= LEARN_BOUND_RST;
            r_min_margin  <= MIN_MARGIN_RST;
            r_max_margin  <= MAX_MARGIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LEARN_BOUND: r_learn_bound <= i_cfg_data;
                REG_MIN_MARGIN:  r_min_margin  <= i_cfg_data;
                REG_MAX_MARGIN:  r_max_margin  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cbs_hdr_store u_hdr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (i_s_tdata[15:0]),
        .o_rd_data (hdr_q),
        .i_wr_en   (hdr_we),
        .i_wr_addr (r_px),
        .i_wr_data (hdr_wdata),
        .o_busy    (hdr_busy)
    );

    cbs_cw_alu u_alu (
        .i_cw         (r_cw_q),
        .i_pix        (r_pix),
        .i_box_hi     (r_box_hi),
        .i_box_lo     (r_box_lo),
        .i_time       (r_t),
        .i_min_margin (r_min_margin),
        .i_max_margin (r_max_margin),
        .o_flags      (flags),
        .o_cw_hit     (cw_hit),
        .o_cw_aged    (cw_aged),
        .o_cw_kept    (cw_kept)
    );

    // Learn time: restart on an empty codebook, then tick with saturation
    always_comb begin
        t_learn = (hdr_q.count == '0) ? TIME_W'(1) :
                  (hdr_q.ptime == TIME_MAX) ? TIME_MAX : hdr_q.ptime + 1'b1;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = ST_HDR;
            ST_HDR: begin
                if (hdr_q.count != '0 && r_op != OP_UNDEF) n_state = ST_SCAN;
                else n_state = ST_FIN;
            end
            ST_SCAN: if (!more) n_state = ST_FIN;
            ST_FIN:  if (fin_go) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // New codeword built from the box and the pixel
    always_comb begin
        cw_new.learn_hi = r_box_hi;
        cw_new.learn_lo = r_box_lo;
        cw_new.top      = r_pix;
        cw_new.bot      = r_pix;
        cw_new.last_upd = r_t;
        cw_new.stale    = '0;
    end

    // Result of the finishing step
    always_comb begin
        fin_added   = (r_op == OP_LEARN) && !r_found && (r_cnt < ENTRIES_C);
        fin_dropped = (r_op == OP_LEARN) && !r_found && (r_cnt >= ENTRIES_C);
        fin_fg      = (r_op == OP_DIFF) && !r_found;
        if (r_op == OP_CLEAR) fin_cnt = r_keep;
        else if (fin_added) fin_cnt = r_cnt + 1'b1;
        else fin_cnt = r_cnt;
    end

    // Memory controls
    always_comb begin
        cw_re     = 1'b0;
        cw_rk     = '0;
        cw_we     = 1'b0;
        cw_wk     = r_k;
        cw_wdata  = cw_aged;
        hdr_we    = 1'b0;
        hdr_wdata = '0;
        unique case (r_state)
            ST_HDR: cw_re = (hdr_q.count != '0);
            ST_SCAN: begin
                cw_re = more;
                cw_rk = r_k + 1'b1;
                unique case (r_op)
                    OP_LEARN: begin
                        cw_we    = 1'b1;
                        cw_wdata = (!r_found && flags.learn_hit) ? cw_hit : cw_aged;
                    end
                    OP_CLEAR: begin
                        cw_we    = flags.keep;
                        cw_wk    = r_keep[K_W-1:0];
                        cw_wdata = cw_kept;
                    end
                    default: ;
                endcase
            end
            ST_FIN: begin
                if (fin_go) begin
                    cw_we    = fin_added;
                    cw_wk    = r_cnt[K_W-1:0];
                    cw_wdata = cw_new;
                    hdr_we   = (r_op == OP_LEARN) || (r_op == OP_CLEAR);
                    hdr_wdata.ptime = (r_op == OP_LEARN) ? r_t : '0;
                    hdr_wdata.count = fin_cnt;
                end
            end
            default: ;
        endcase
    end

    // Codeword memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (cw_we) cw_mem[{r_px, cw_wk}] <= cw_wdata;
        if (cw_re) r_cw_q <= cw_mem[{r_px, cw_rk}];
    end

    // Sequencer and item registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_s_tuser;
            r_px  <= i_s_tdata[15:0];
            for (int n = 0; n < CHANNELS; n++) begin
                r_pix[n]    <= i_s_tdata[16 + 8*n +: 8];
                r_box_hi[n] <= (({1'b0, i_s_tdata[16 + 8*n +: 8]} + {1'b0, r_learn_bound})
                                > {1'b0, CH_MAX}) ? CH_MAX
                               : i_s_tdata[16 + 8*n +: 8] + r_learn_bound;
                r_box_lo[n] <= (i_s_tdata[16 + 8*n +: 8] >= r_learn_bound)
                               ? i_s_tdata[16 + 8*n +: 8] - r_learn_bound : 8'd0;
            end
        end
        unique case (r_state)
            ST_HDR: begin
                r_cnt   <= hdr_q.count;
                r_t     <= (r_op == OP_LEARN) ? t_learn : hdr_q.ptime;
                r_k     <= '0;
                r_keep  <= '0;
                r_found <= 1'b0;
            end
            ST_SCAN: begin
                r_k <= r_k + 1'b1;
                if (r_op == OP_LEARN && flags.learn_hit) r_found <= 1'b1;
                if (r_op == OP_DIFF && flags.diff_hit) r_found <= 1'b1;
                if (r_op == OP_CLEAR && flags.keep) r_keep <= r_keep + 1'b1;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FIN && fin_go) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && fin_go) begin
            r_out_data <= {1'b0, fin_dropped, fin_added, fin_cnt, fin_fg};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Checks
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ({1'b0, r_k} < r_cnt))
        else $error("scan index beyond codeword count");
    a_keep_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_keep <= {1'b0, r_k}))
        else $error("clear write index ahead of read index");
    a_add_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[5] && o_m_tdata[6]))
        else $error("added and dropped together");
    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hdr_busy |-> !o_s_tready)
        else $error("request taken during header clearing");

endmodule

// ===== rtl/cbs_hdr_store.sv =====
// Per-pixel header memory: pixel time and codeword count.
// Depends on cbs_pkg; runs a clearing pass after reset.
`timescale 1ns / 1ps
module cbs_hdr_store import cbs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [PIX_W-1:0] i_rd_addr,
    output t_hdr             o_rd_data,
    input  logic             i_wr_en,
    input  logic [PIX_W-1:0] i_wr_addr,
    input  t_hdr             i_wr_data,
    output logic             o_busy
);

    t_hdr             mem [PIXELS];
    logic [PIX_W-1:0] r_clr_addr;
    logic             r_busy;
    t_hdr             r_q;

    // Sweep the memory with zeros after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_busy     <= 1'b1;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == PIX_W'(PIXELS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Write port, clearing pass takes precedence
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;
    assign o_busy    = r_busy;

endmodule

// ===== rtl/cbs_cw_alu.sv =====
// Shared codeword unit: match tests, learn update, ageing and clear rewrite.
// Depends on cbs_pkg; purely combinational, used once per scanned codeword.
`timescale 1ns / 1ps
module cbs_cw_alu import cbs_pkg::*; (
    input  t_cword            i_cw,
    input  t_pix              i_pix,
    input  t_pix              i_box_hi,
    input  t_pix              i_box_lo,
    input  logic [TIME_W-1:0] i_time,
    input  logic [7:0]        i_min_margin,
    input  logic [7:0]        i_max_margin,
    output t_cw_flags         o_flags,
    output t_cword            o_cw_hit,
    output t_cword            o_cw_aged,
    output t_cword            o_cw_kept
);

    logic              learn_ok;
    logic              diff_ok;
    logic [TIME_W-1:0] run;

    // Match tests on all channels
    always_comb begin
        learn_ok = 1'b1;
        diff_ok  = 1'b1;
        for (int n = 0; n < CHANNELS; n++) begin
            if (!(i_cw.learn_lo[n] <= i_pix[n] && i_pix[n] <= i_cw.learn_hi[n])) begin
                learn_ok = 1'b0;
            end
            if (!(({1'b0, i_pix[n]} + {1'b0, i_min_margin}) >= {1'b0, i_cw.bot[n]} &&
                  {1'b0, i_pix[n]} <= ({1'b0, i_cw.top[n]} + {1'b0, i_max_margin}))) begin
                diff_ok = 1'b0;
            end
        end
    end

    // Widen the matched codeword and nudge its learn bounds toward the box
    always_comb begin
        o_cw_hit          = i_cw;
        o_cw_hit.last_upd = i_time;
        for (int n = 0; n < CHANNELS; n++) begin
            if (i_cw.top[n] < i_pix[n]) begin
                o_cw_hit.top[n] = i_pix[n];
            end else if (i_cw.bot[n] > i_pix[n]) begin
                o_cw_hit.bot[n] = i_pix[n];
            end
            if (i_cw.learn_hi[n] < i_box_hi[n]) begin
                o_cw_hit.learn_hi[n] = i_cw.learn_hi[n] + 8'd1;
            end
            if (i_cw.learn_lo[n] > i_box_lo[n]) begin
                o_cw_hit.learn_lo[n] = i_cw.learn_lo[n] - 8'd1;
            end
        end
    end

    // Raise staleness to the time since the last update
    always_comb begin
        run       = (i_time >= i_cw.last_upd) ? (i_time - i_cw.last_upd) : '0;
        o_cw_aged = i_cw;
        if (i_cw.stale < run) begin
            o_cw_aged.stale = run;
        end
    end

    // Survivor of a clear: times restart
    always_comb begin
        o_cw_kept          = i_cw;
        o_cw_kept.stale    = '0;
        o_cw_kept.last_upd = '0;
    end

    assign o_flags.learn_hit = learn_ok;
    assign o_flags.diff_hit  = diff_ok;
    assign o_flags.keep      = (i_cw.stale <= i_time);

endmodule
